/* rtl/gwws_pkg.sv */
// ----------------------------------------------------------------------------
// gwws_pkg
// Shared types and constants for the greedy word wrap stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package gwws_pkg;

  localparam int unsigned MAX_WORD_DEF = 32;

  localparam logic [7:0] LINE_WIDTH_RST = 8'd80;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_NONE  = 8'd0;

  // newlines in a row that make a paragraph break
  localparam logic [1:0] PARA_RUN = 2'd2;

  // source of one result byte
  typedef enum logic [1:0] {
    SEL_NL   = 2'd0,
    SEL_SP   = 2'd1,
    SEL_WORD = 2'd2,
    SEL_STAT = 2'd3
  } sel_e;

  // what one accepted item asks to be emitted, in emission order
  typedef struct packed {
    logic par;        // two newlines
    logic pre;        // separator before the word
    logic pre_space;  // separator is a space, else a newline
    logic word;       // word bytes from the buffer
    logic post;       // newline after the word
    logic stat;       // status-only end result
  } plan_t;

  typedef struct packed {
    logic accept;
    logic emit;
    sel_e sel;
    logic last;
  } cmd_t;

  typedef struct packed {
    plan_t plan;
    logic  word_last;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/gwws_dp.sv */
// ----------------------------------------------------------------------------
// gwws_dp
// Datapath: word buffer, line state, placement decision and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gwws_dp #(
  parameter int unsigned MaxWord = gwws_pkg::MAX_WORD_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  input  wire logic [7:0]    line_width_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          end_of_text_i,
  input  wire logic          out_stall_i,
  input  wire gwws_pkg::cmd_t cmd_i,
  output gwws_pkg::sts_t     sts_o,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               byte_valid_o,
  output logic               last_of_run_o,
  output logic               wrap_failed_o
);

  localparam int unsigned LenW  = $clog2(MaxWord + 1);
  localparam int unsigned AddrW = $clog2(MaxWord);
  localparam int unsigned SumW  = ((LenW > 9) ? LenW : 9) + 1;

  logic [7:0]      mem_q [MaxWord];
  logic [7:0]      rdata_q;

  logic [7:0]      width_q;
  logic [LenW-1:0] word_len_q;
  logic [8:0]      line_pos_q;
  logic [1:0]      nl_run_q;
  logic            fail_q;
  logic            rep_fail_q;
  logic [LenW-1:0] emit_len_q;
  logic [LenW-1:0] idx_q, idx_d;

  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            byte_valid_q;
  logic            last_q;
  logic            wrap_q;

  logic            is_ws;
  logic            is_nl;
  logic [1:0]      nl_next;
  logic            par;
  logic            place;
  logic            over;
  logic [SumW-1:0] wl_ext;
  logic [SumW-1:0] w_ext;
  logic [SumW-1:0] lp0;
  logic [SumW-1:0] sum;
  logic [SumW-1:0] gap;
  logic [SumW-1:0] lp_new;
  logic            pre;
  logic            pre_space;
  logic            post;
  logic            fail_new;
  logic            word_step;
  gwws_pkg::plan_t plan;

  always_comb begin
    is_ws   = ((in_byte_i >= gwws_pkg::CH_TAB) && (in_byte_i <= gwws_pkg::CH_CR)) ||
              (in_byte_i == gwws_pkg::CH_SPACE);
    is_nl   = (in_byte_i == gwws_pkg::CH_NL);
    nl_next = nl_run_q + (is_nl ? 2'd1 : 2'd0);
    par     = !end_of_text_i && is_ws && (nl_next == gwws_pkg::PARA_RUN);
    place   = (end_of_text_i || is_ws) && (word_len_q != '0);

    wl_ext = {{(SumW-LenW){1'b0}}, word_len_q};
    w_ext  = {{(SumW-8){1'b0}}, width_q};
    lp0    = par ? '0 : {{(SumW-9){1'b0}}, line_pos_q};
    gap    = end_of_text_i ? '0 : {{(SumW-1){1'b0}}, 1'b1};
    sum    = lp0 + wl_ext;
    over   = wl_ext > w_ext;

    pre       = 1'b0;
    pre_space = 1'b0;
    post      = 1'b0;
    lp_new    = sum + gap;
    priority if (over && (lp0 == '0)) begin
      post   = 1'b1;
      lp_new = '0;
    end else if (over) begin
      pre    = 1'b1;
      post   = 1'b1;
      lp_new = '0;
    end else if (sum > w_ext) begin
      pre    = 1'b1;
      lp_new = wl_ext + gap;
    end else if (sum == w_ext) begin
      pre       = (lp0 != '0);
      pre_space = 1'b1;
      post      = 1'b1;
      lp_new    = '0;
    end else begin
      pre       = (lp0 != '0);
      pre_space = 1'b1;
    end

    plan.par       = par;
    plan.pre       = place && pre;
    plan.pre_space = pre_space;
    plan.word      = place;
    plan.post      = place && post;
    plan.stat      = end_of_text_i;

    fail_new = fail_q | (place && over);
  end

  assign word_step = cmd_i.emit && (cmd_i.sel == gwws_pkg::SEL_WORD);

  always_comb begin
    priority if (cmd_i.accept) begin
      idx_d = '0;
    end else if (word_step) begin
      idx_d = idx_q + LenW'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  // word buffer; the read port follows the next index so data is ready on time
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !end_of_text_i && !is_ws && (word_len_q < LenW'(MaxWord))) begin
      mem_q[word_len_q[AddrW-1:0]] <= in_byte_i;
    end
    rdata_q <= mem_q[idx_d[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= gwws_pkg::LINE_WIDTH_RST;
      word_len_q <= '0;
      line_pos_q <= '0;
      nl_run_q   <= '0;
      fail_q     <= 1'b0;
      rep_fail_q <= 1'b0;
      emit_len_q <= '0;
      idx_q      <= '0;
    end else begin
      idx_q <= idx_d;
      if (cfg_valid_i) begin
        width_q <= line_width_i;
      end
      if (cmd_i.accept) begin
        if (end_of_text_i) begin
          word_len_q <= '0;
          line_pos_q <= '0;
          nl_run_q   <= '0;
          fail_q     <= 1'b0;
          rep_fail_q <= fail_new;
          emit_len_q <= word_len_q;
        end else if (is_ws) begin
          word_len_q <= '0;
          line_pos_q <= place ? lp_new[8:0] : lp0[8:0];
          nl_run_q   <= par ? 2'd0 : nl_next;
          fail_q     <= fail_new;
          rep_fail_q <= fail_new;
          emit_len_q <= word_len_q;
        end else begin
          nl_run_q <= '0;
          if (word_len_q < LenW'(MaxWord)) begin
            word_len_q <= word_len_q + LenW'(1);
          end else begin
            fail_q <= 1'b1;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      unique case (cmd_i.sel)
        gwws_pkg::SEL_NL:   out_byte_q <= gwws_pkg::CH_NL;
        gwws_pkg::SEL_SP:   out_byte_q <= gwws_pkg::CH_SPACE;
        gwws_pkg::SEL_WORD: out_byte_q <= rdata_q;
        gwws_pkg::SEL_STAT: out_byte_q <= gwws_pkg::CH_NONE;
        default:            out_byte_q <= gwws_pkg::CH_NONE;
      endcase
      byte_valid_q <= (cmd_i.sel != gwws_pkg::SEL_STAT);
      last_q       <= cmd_i.last;
      wrap_q       <= rep_fail_q;
    end
  end

  assign sts_o.plan      = plan;
  assign sts_o.word_last = ((idx_q + LenW'(1)) == emit_len_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = byte_valid_q;
  assign last_of_run_o = last_q;
  assign wrap_failed_o = wrap_q;

endmodule

`default_nettype wire

/* rtl/gwws_ctrl.sv */
// ----------------------------------------------------------------------------
// gwws_ctrl
// Controller: takes items and steps through the results each one causes.
// ----------------------------------------------------------------------------
`default_nettype none

module gwws_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire gwws_pkg::sts_t sts_i,
  output gwws_pkg::cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PAR1 = 7'b0000010,
    S_PAR2 = 7'b0000100,
    S_PRE  = 7'b0001000,
    S_WORD = 7'b0010000,
    S_POST = 7'b0100000,
    S_STAT = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  gwws_pkg::plan_t plan_q;
  state_e          nxt;
  logic            accept;
  logic            emit;
  logic            stay;

  function automatic state_e from_stat(gwws_pkg::plan_t p);
    return p.stat ? S_STAT : S_IDLE;
  endfunction

  function automatic state_e from_post(gwws_pkg::plan_t p);
    return p.post ? S_POST : from_stat(p);
  endfunction

  function automatic state_e from_word(gwws_pkg::plan_t p);
    return p.word ? S_WORD : from_post(p);
  endfunction

  function automatic state_e from_pre(gwws_pkg::plan_t p);
    return p.pre ? S_PRE : from_word(p);
  endfunction

  function automatic state_e after(gwws_pkg::plan_t p, state_e s);
    state_e r;
    unique case (s)
      S_IDLE:  r = p.par ? S_PAR1 : from_pre(p);
      S_PAR1:  r = S_PAR2;
      S_PAR2:  r = from_pre(p);
      S_PRE:   r = from_word(p);
      S_WORD:  r = from_post(p);
      S_POST:  r = from_stat(p);
      S_STAT:  r = S_IDLE;
      default: r = S_IDLE;
    endcase
    return r;
  endfunction

  always_comb begin
    accept = in_valid_i && (state_q == S_IDLE);
    emit   = (state_q != S_IDLE) && sts_i.out_free;
    // word bytes repeat until the last one is out
    stay   = (state_q == S_WORD) && !sts_i.word_last;
    nxt    = after(plan_q, state_q);

    state_d = state_q;
    if (accept) begin
      state_d = after(sts_i.plan, S_IDLE);
    end else if (emit && !stay) begin
      state_d = nxt;
    end

    cmd_o.accept = accept;
    cmd_o.emit   = emit;
    cmd_o.last   = !stay && (nxt == S_IDLE);
    unique case (state_q)
      S_PRE:   cmd_o.sel = plan_q.pre_space ? gwws_pkg::SEL_SP : gwws_pkg::SEL_NL;
      S_WORD:  cmd_o.sel = gwws_pkg::SEL_WORD;
      S_STAT:  cmd_o.sel = gwws_pkg::SEL_STAT;
      default: cmd_o.sel = gwws_pkg::SEL_NL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      plan_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        plan_q <= sts_i.plan;
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* rtl/greedy_word_wrap_stream.sv */
// ----------------------------------------------------------------------------
// greedy_word_wrap_stream
// Greedy word wrap of a byte stream against a programmable line width.
// ----------------------------------------------------------------------------
// A printable text byte goes into the word buffer and gives no result, so
// the next transaction is taken on the following cycle. A whitespace or
// end-of-text item is taken and then causes its results in order (paragraph
// break, separator, the buffered word replayed byte by byte from the buffer's
// registered read port, trailing newline, status), at most MaxWord + 4
// results, with no new item taken until the last result has entered the
// output register; stalls on the output side hold the results back. Results
// wait in a one-deep output register while the next item is taken. The user
// writes line_width through the cfg port (always ready) only while the block
// is idle; the block itself does not enforce it.
`default_nettype none

module greedy_word_wrap_stream #(
  parameter int unsigned MaxWord = gwws_pkg::MAX_WORD_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] line_width_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_text_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            last_of_run_o,
  output logic            wrap_failed_o
);

  gwws_pkg::cmd_t cmd;
  gwws_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  gwws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gwws_dp #(
    .MaxWord (MaxWord)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .line_width_i  (line_width_i),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_stall_i   (out_stall_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_of_run_o (last_of_run_o),
    .wrap_failed_o (wrap_failed_o)
  );

endmodule

`default_nettype wire

/* rtl/gwws_checker.sv */
// ----------------------------------------------------------------------------
// gwws_checker
// Port-level checks for the greedy word wrap stream block.
// ----------------------------------------------------------------------------
`default_nettype none

module gwws_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] in_byte_i,
  input wire logic       end_of_text_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       byte_valid_o,
  input wire logic       last_of_run_o
);

  logic printable;

  assign printable = !end_of_text_i &&
                     !((in_byte_i >= gwws_pkg::CH_TAB && in_byte_i <= gwws_pkg::CH_CR) ||
                       in_byte_i == gwws_pkg::CH_SPACE);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(byte_valid_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // the status result closes its run
  a_stat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> last_of_run_o)
    else $error("status result not last of run");

  // the status result carries no byte
  a_stat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> out_byte_o == gwws_pkg::CH_NONE)
    else $error("status result carries a byte");

  // a printable byte gives no result, so the block is ready again at once
  a_print_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && printable |=> !in_stall_o)
    else $error("printable byte held the input");

endmodule

bind greedy_word_wrap_stream gwws_checker u_gwws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .in_byte_i     (in_byte_i),
  .end_of_text_i (end_of_text_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .byte_valid_o  (byte_valid_o),
  .last_of_run_o (last_of_run_o)
);

`default_nettype wire
